// ===== hw/rtl/slcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_pkg - shared types, constants and functions of the sync/length deframer
// Holds the frame constants, the byte-wise CRC-16 step and the header hunt
// step used by the deframer core.
// ----------------------------------------------------------------------------
package slcd_pkg;

   // Field widths
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 10;
   localparam int unsigned IDX_W  = 9;
   localparam int unsigned CRC_W  = 16;
   localparam int unsigned CNT_W  = 3;

   // Frame constants
   localparam int unsigned       HDR_LEN         = 6;
   localparam logic [CNT_W-1:0]  HDR_CNT         = CNT_W'(HDR_LEN);
   localparam logic [BYTE_W-1:0] SYNC_A          = 8'h5A;
   localparam logic [BYTE_W-1:0] SYNC_B          = 8'hA5;
   localparam logic [CRC_W-1:0]  CRC_POLY        = 16'h1021;
   localparam int unsigned       MAX_PAYLOAD_DEF = 512;
   localparam logic [LEN_W-1:0]  MAX_LEN_RESET   = 10'd512;

   // Phase codes
   localparam logic PH_HUNT    = 1'b0;
   localparam logic PH_PAYLOAD = 1'b1;

   typedef logic [HDR_LEN-1:0][BYTE_W-1:0] hdr_store_type;

   // Header collection state
   typedef struct packed {
      logic [CNT_W-1:0] count;
      hdr_store_type    store;
   } hunt_type;

   // Input stage to core
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] rx_byte;
   } in_type;

   // Result payload
   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic [IDX_W-1:0]  byte_index;
      logic [LEN_W-1:0]  frame_length;
      logic              frame_last;
      logic              crc_ok;
      logic [CRC_W-1:0]  crc_error_total;
   } rsp_type;

   // One byte of CRC-16, poly 0x1021, MSB first
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

   // CRC after the two sync bytes, fixed for every frame
   localparam logic [CRC_W-1:0] CRC_SYNC = crc_byte(crc_byte(16'h0000, SYNC_A), SYNC_B);

   // One byte of sync hunt and header collection
   function automatic hunt_type hunt_step(input hunt_type h, input logic [BYTE_W-1:0] b);
      hunt_type r;
      r = h;
      case (h.count) inside
         3'd0: begin
            if (b == SYNC_A) begin
               r.store[0] = b;
               r.count    = 3'd1;
            end
         end
         3'd1: begin
            if (b == SYNC_B) begin
               r.store[1] = b;
               r.count    = 3'd2;
            end else if (b == SYNC_A) begin
               r.count = 3'd1;
            end else begin
               r.count = 3'd0;
            end
         end
         [3'd2:3'd5]: begin
            r.store[h.count] = b;
            r.count          = h.count + 3'd1;
         end
         default: begin
            r.count = 3'd0;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/slcd_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_req_if - received byte channel
// Valid/ready channel carrying one received byte per transfer.
// ----------------------------------------------------------------------------
interface slcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/slcd_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_rsp_if - payload byte channel
// Valid/ready channel carrying one payload byte and its frame status.
// ----------------------------------------------------------------------------
interface slcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic [8:0]  byte_index;
   logic [9:0]  frame_length;
   logic        frame_last;
   logic        crc_ok;
   logic [15:0] crc_error_total;

   modport source (output valid, output payload_byte, output byte_index,
                   output frame_length, output frame_last, output crc_ok,
                   output crc_error_total, input ready);
   modport sink   (input valid, input payload_byte, input byte_index,
                   input frame_length, input frame_last, input crc_ok,
                   input crc_error_total, output ready);
endinterface

// ===== hw/rtl/slcd_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_in_stage - input register of the deframer
// Captures one received byte per transfer and holds it until the core takes it.
// ----------------------------------------------------------------------------
module slcd_in_stage (
   input  logic             clock,
   input  logic             reset,
   slcd_req_if.sink         req_chan,
   input  logic             take,
   output slcd_pkg::in_type in_item
);
   import slcd_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              accept;

   // Free when empty or when the held byte moves on this cycle
   assign req_chan.ready = !in_valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.rx_byte;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   assign in_item.valid   = in_valid_ff;
   assign in_item.rx_byte = in_byte_ff;

endmodule

// ===== hw/rtl/slcd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_core - frame state and result register
// Hunts for sync, checks the header, runs the CRC over header and payload and
// registers one result per payload byte.
// ----------------------------------------------------------------------------
module slcd_core #(
   parameter int unsigned MAX_PAYLOAD = slcd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [slcd_pkg::LEN_W-1:0]    max_len,
   input  slcd_pkg::in_type              in_item,
   output logic                          take,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output slcd_pkg::rsp_type             rsp_data
);
   import slcd_pkg::*;

   localparam logic [15:0] LEN_CAP = 16'(MAX_PAYLOAD);

   logic             phase_ff, phase_in;
   hunt_type         hunt_ff, hunt_in;
   logic [LEN_W-1:0] payload_len_ff, payload_len_in;
   logic [LEN_W-1:0] payload_count_ff, payload_count_in;
   logic [CRC_W-1:0] crc_ff, crc_in;
   logic [CRC_W-1:0] crc_errors_ff, crc_errors_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             out_free;
   logic             produce;
   hunt_type         hunt_a, hunt_r;
   logic [15:0]      hdr_len, limit;
   logic             bad_len;
   logic [CRC_W-1:0] crc_hdr, crc_pay, crc_exp;
   logic [LEN_W:0]   count_next;
   logic             last, ok;

   // Handshake with the result register
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign take     = in_item.valid && out_free;

   // Header path: hunt step, length check, rescan of the kept bytes
   always_comb begin
      hunt_a  = hunt_step(hunt_ff, in_item.rx_byte);
      hdr_len = {hunt_a.store[3], hunt_a.store[2]};
      limit   = ({6'd0, max_len} > LEN_CAP) ? LEN_CAP : {6'd0, max_len};
      bad_len = (hdr_len == 16'd0) || (hdr_len > limit);
      crc_hdr = crc_byte(crc_byte(CRC_SYNC, hunt_a.store[2]), hunt_a.store[3]);
      hunt_r       = hunt_a;
      hunt_r.count = '0;
      for (int i = 1; i < HDR_LEN; i++) begin
         hunt_r = hunt_step(hunt_r, hunt_a.store[i]);
      end
   end

   // Payload path
   assign crc_pay    = crc_byte(crc_ff, in_item.rx_byte);
   assign crc_exp    = {hunt_ff.store[5], hunt_ff.store[4]};
   assign count_next = {1'b0, payload_count_ff} + 11'd1;
   assign last       = count_next >= {1'b0, payload_len_ff};
   assign ok         = last && (crc_pay == crc_exp);

   // Next state and result
   always_comb begin
      phase_in         = phase_ff;
      hunt_in          = hunt_ff;
      payload_len_in   = payload_len_ff;
      payload_count_in = payload_count_ff;
      crc_in           = crc_ff;
      crc_errors_in    = crc_errors_ff;
      rsp_data_in      = rsp_data_ff;
      produce          = 1'b0;
      if (take) begin
         if (phase_ff == PH_HUNT) begin
            if (hunt_a.count == HDR_CNT) begin
               if (bad_len) begin
                  hunt_in = hunt_r;
               end else begin
                  hunt_in          = hunt_a;
                  hunt_in.count    = '0;
                  crc_in           = crc_hdr;
                  payload_len_in   = hdr_len[LEN_W-1:0];
                  payload_count_in = '0;
                  phase_in         = PH_PAYLOAD;
               end
            end else begin
               hunt_in = hunt_a;
            end
         end else begin
            produce = 1'b1;
            crc_in  = crc_pay;
            if (last) begin
               if (!ok && (crc_errors_ff != 16'hFFFF)) begin
                  crc_errors_in = crc_errors_ff + 16'd1;
               end
               phase_in         = PH_HUNT;
               hunt_in.count    = '0;
               payload_count_in = '0;
            end else begin
               payload_count_in = count_next[LEN_W-1:0];
            end
            rsp_data_in.payload_byte    = in_item.rx_byte;
            rsp_data_in.byte_index      = payload_count_ff[IDX_W-1:0];
            rsp_data_in.frame_length    = payload_len_ff;
            rsp_data_in.frame_last      = last;
            rsp_data_in.crc_ok          = ok;
            rsp_data_in.crc_error_total = crc_errors_in;
         end
      end
      rsp_valid_in = produce || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         hunt_ff.count    <= '0;
         payload_len_ff   <= '0;
         payload_count_ff <= '0;
         crc_ff           <= '0;
         crc_errors_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         hunt_ff.count    <= hunt_in.count;
         payload_len_ff   <= payload_len_in;
         payload_count_ff <= payload_count_in;
         crc_ff           <= crc_in;
         crc_errors_ff    <= crc_errors_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      hunt_ff.store <= hunt_in.store;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/sync_length_crc16_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_crc16_deframer_unit - sync/length/CRC-16 frame deframer
// Finds 0x5A 0xA5 framed packets in a byte stream and passes out the payload.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one received byte per transfer. rsp_chan carries one
//   payload byte per transfer with its index, the announced length, a last
//   flag, the CRC verdict (on the last byte only) and the running count of
//   frames that failed the CRC. Header bytes and noise give no transfer.
//   csr_wr_en/csr_wr_data set the largest accepted payload length (reset
//   512); a header with a zero or larger length is rescanned for sync. The
//   user writes the register only while no bytes are in flight; not enforced.
// Timing:
//   A byte goes from req transfer through the input register and the result
//   register to rsp valid. One byte is accepted every cycle unless rsp_chan
//   stalls; the per-byte CRC step and header check sit in a single stage.
// Reset and stall:
//   Synchronous reset returns to sync hunt, clears the error count and
//   empties both registers. While rsp_chan is stalled with a result held,
//   the input register keeps its byte and req_chan drops ready once full.
// ----------------------------------------------------------------------------
module sync_length_crc16_deframer_unit #(
   parameter int unsigned MAX_PAYLOAD = slcd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   slcd_req_if.sink                   req_chan,
   slcd_rsp_if.source                 rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [slcd_pkg::LEN_W-1:0] csr_wr_data
);
   import slcd_pkg::*;

   logic [LEN_W-1:0] max_len_ff;
   in_type           in_item;
   logic             take;
   logic             rsp_valid;
   rsp_type          rsp_data;

   // Length limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   slcd_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .in_item  (in_item)
   );

   slcd_core #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .max_len   (max_len_ff),
      .in_item   (in_item),
      .take      (take),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Result channel
   assign rsp_chan.valid           = rsp_valid;
   assign rsp_chan.payload_byte    = rsp_data.payload_byte;
   assign rsp_chan.byte_index      = rsp_data.byte_index;
   assign rsp_chan.frame_length    = rsp_data.frame_length;
   assign rsp_chan.frame_last      = rsp_data.frame_last;
   assign rsp_chan.crc_ok          = rsp_data.crc_ok;
   assign rsp_chan.crc_error_total = rsp_data.crc_error_total;

   // Verdict only on the last byte of a frame
   a_ok_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.crc_ok |-> rsp_data.frame_last)
      else $error("crc_ok set on a non-final payload byte");

   // Index stays inside the announced length
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.byte_index} < rsp_data.frame_length))
      else $error("byte_index outside frame length");

   // A failed frame always leaves a nonzero error count (the count saturates)
   a_fail_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_last && !rsp_data.crc_ok
      |-> (rsp_data.crc_error_total != 16'd0))
      else $error("CRC failure not reflected in error count");

   // No input is taken while the result register is stalled and full
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_chan.ready |-> !take)
      else $error("core advanced while result was stalled");

endmodule
